// ----- rtl/rm3s_pkg.sv -----
package rm3s_pkg;

  localparam int RANGE_W   = 16;
  localparam int RAW_W     = 16;
  localparam int TIME_W    = 32;
  localparam int OUT_W     = 15;
  localparam int SHORT_W   = 10;
  localparam int LONG_W    = 14;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W    = 34;
  localparam int SLOT_N    = 3;
  localparam int SLOT_W    = 2;
  localparam int OUT_MAX   = 32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUND  = 3'd0,
    REG_POLL    = 3'd1,
    REG_DELAY   = 3'd2,
    REG_FRESH   = 3'd3,
    REG_TIMEOUT = 3'd4
  } cfg_reg_t;

  localparam logic [SHORT_W-1:0] GROUND_RST  = 10'd5;
  localparam logic [SHORT_W-1:0] POLL_RST    = 10'd50;
  localparam logic [SHORT_W-1:0] DELAY_RST   = 10'd25;
  localparam logic [LONG_W-1:0]  FRESH_RST   = 14'd500;
  localparam logic [LONG_W-1:0]  TIMEOUT_RST = 14'd200;

  typedef struct packed {
    logic [SHORT_W-1:0] ground_range_cm;
    logic [SHORT_W-1:0] poll_period_ms;
    logic [SHORT_W-1:0] sample_delay_ms;
    logic [LONG_W-1:0]  fresh_age_ms;
    logic [LONG_W-1:0]  no_data_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic                    sensor_healthy;
    logic signed [RAW_W-1:0] raw_range_cm;
    logic                    takeoff_seen;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  range_cm;
    logic [TIME_W-1:0] stamp_ms;
    logic              from_fallback;
  } out_item_t;

  function automatic logic signed [RANGE_W-1:0] clip_range(logic signed [RAW_W-1:0] v);
    logic signed [WIDE_W-1:0] ext;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] res;
    ext = WIDE_W'(v);
    hi  = (WIDE_W'(1) <<< (RANGE_W - 1)) - WIDE_W'(1);
    lo  = -hi - WIDE_W'(1);
    if (ext > hi) begin
      res = hi;
    end else if (ext < lo) begin
      res = lo;
    end else begin
      res = ext;
    end
    return res[RANGE_W-1:0];
  endfunction

endpackage

// ----- rtl/rm3s_core.sv -----
module rm3s_core
  import rm3s_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      fire,
  output logic      emit,
  output out_item_t result
);

  logic [TIME_W-1:0]        last_poll_r;
  logic [SLOT_W-1:0]        write_slot_r;
  logic [TIME_W-1:0]        slot_times_r [SLOT_N];
  logic signed [RANGE_W-1:0] slot_ranges_r [SLOT_N];
  logic [TIME_W-1:0]        last_emit_r;
  logic [TIME_W-1:0]        last_valid_r;

  logic                     poll;
  logic                     wr;
  logic [SLOT_W-1:0]        slot_nxt;
  logic [TIME_W-1:0]        stamp_new;
  logic signed [RANGE_W-1:0] range_new;
  logic [TIME_W-1:0]        cur_t [SLOT_N];
  logic signed [RANGE_W-1:0] cur_r [SLOT_N];
  logic [SLOT_N-1:0]        fresh;
  logic [TIME_W-1:0]        age;
  logic                     all_fresh;
  logic                     lo_idx;
  logic [SLOT_W-1:0]        med_idx;
  logic signed [RANGE_W-1:0] med_r;
  logic [TIME_W-1:0]        med_t;
  logic signed [WIDE_W-1:0] med_ext;
  logic signed [WIDE_W-1:0] gnd_ext;
  logic signed [WIDE_W-1:0] out_ext;
  logic                     timeout_hit;
  logic                     emit_med;
  logic                     emit_fb;
  logic [TIME_W-1:0]        last_emit_nxt;

  always_comb begin
    poll      = (item.now_ms - last_poll_r) > TIME_W'(cfg.poll_period_ms);
    wr        = poll && item.sensor_healthy;
    slot_nxt  = (write_slot_r >= SLOT_W'(SLOT_N - 1)) ? '0 : write_slot_r + SLOT_W'(1);
    stamp_new = item.now_ms - TIME_W'(cfg.sample_delay_ms);
    range_new = clip_range(item.raw_range_cm);
    for (int i = 0; i < SLOT_N; i++) begin
      if (wr && slot_nxt == SLOT_W'(i)) begin
        cur_t[i] = stamp_new;
        cur_r[i] = range_new;
        age      = TIME_W'(cfg.sample_delay_ms);
      end else begin
        cur_t[i] = slot_times_r[i];
        cur_r[i] = slot_ranges_r[i];
        age      = item.now_ms - slot_times_r[i];
      end
      fresh[i] = age < TIME_W'(cfg.fresh_age_ms);
    end
    all_fresh = &fresh;

    // lo is slot 1 only when slot 0 is strictly greater
    lo_idx = cur_r[0] > cur_r[1];
    if (cur_r[2] > cur_r[!lo_idx]) begin
      med_idx = SLOT_W'(!lo_idx);
    end else if (cur_r[2] < cur_r[lo_idx]) begin
      med_idx = SLOT_W'(lo_idx);
    end else begin
      med_idx = SLOT_W'(2);
    end
    case (med_idx)
      2'd0:    begin med_r = cur_r[0]; med_t = cur_t[0]; end
      2'd1:    begin med_r = cur_r[1]; med_t = cur_t[1]; end
      default: begin med_r = cur_r[2]; med_t = cur_t[2]; end
    endcase

    med_ext = WIDE_W'(med_r);
    gnd_ext = $signed(WIDE_W'(cfg.ground_range_cm));
    if (med_ext < gnd_ext) begin
      out_ext = gnd_ext;
    end else if (med_ext > WIDE_W'(OUT_MAX)) begin
      out_ext = WIDE_W'(OUT_MAX);
    end else begin
      out_ext = med_ext;
    end

    timeout_hit = (item.now_ms - last_valid_r) > TIME_W'(cfg.no_data_timeout_ms);
    emit_med    = poll && all_fresh;
    emit_fb     = poll && !all_fresh && !item.takeoff_seen && timeout_hit;
    emit        = emit_med || emit_fb;

    if (emit_med) begin
      last_emit_nxt        = (med_t > last_emit_r) ? med_t : last_emit_r;
      result.range_cm      = out_ext[OUT_W-1:0];
      result.stamp_ms      = last_emit_nxt;
      result.from_fallback = 1'b0;
    end else begin
      last_emit_nxt        = emit_fb ? item.now_ms : last_emit_r;
      result.range_cm      = OUT_W'(cfg.ground_range_cm);
      result.stamp_ms      = item.now_ms;
      result.from_fallback = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_poll_r  <= '0;
      write_slot_r <= '0;
      last_emit_r  <= '0;
      last_valid_r <= '0;
      for (int i = 0; i < SLOT_N; i++) begin
        slot_times_r[i]  <= '0;
        slot_ranges_r[i] <= '0;
      end
    end else if (fire && poll) begin
      last_poll_r <= item.now_ms;
      last_emit_r <= last_emit_nxt;
      if (wr) begin
        write_slot_r <= slot_nxt;
        for (int i = 0; i < SLOT_N; i++) begin
          slot_times_r[i]  <= cur_t[i];
          slot_ranges_r[i] <= cur_r[i];
        end
      end
      if (emit) begin
        last_valid_r <= item.now_ms;
      end
    end
  end

endmodule

// ----- rtl/range_median3_sampler_unit.sv -----
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_data    (in_item_t)
// out       out   out_valid / out_ready  out_data   (out_item_t)
// cfg       in    cfg_we                 cfg_index, cfg_wdata
//
// one tick per cycle sustained unless the output register stalls a result;
// a tick is held in the input register, its result in the output register
// a tick that causes no result leaves the input register without stalling
// synchronous active-low reset empties both registers, clears the state and
// loads the config defaults
// a full output register stalls only a tick that produces a result
module range_median3_sampler_unit
  import rm3s_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      core_emit;
  out_item_t core_result;
  logic      out_free;
  logic      s1_go;
  logic      in_xfer;
  logic      s1_valid_nxt;
  logic      out_valid_nxt;

  rm3s_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (s1_item_r),
    .fire   (s1_go),
    .emit   (core_emit),
    .result (core_result)
  );

  always_comb begin
    out_free      = !out_valid_r || out_ready;
    s1_go         = s1_valid_r && (!core_emit || out_free);
    in_ready      = !s1_valid_r || s1_go;
    in_xfer       = in_valid && in_ready;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_go);
    out_valid_nxt = (s1_go && core_emit) || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (s1_go && core_emit) begin
      out_data_r <= core_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ground_range_cm    <= GROUND_RST;
      cfg_r.poll_period_ms     <= POLL_RST;
      cfg_r.sample_delay_ms    <= DELAY_RST;
      cfg_r.fresh_age_ms       <= FRESH_RST;
      cfg_r.no_data_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GROUND:  cfg_r.ground_range_cm    <= cfg_wdata[SHORT_W-1:0];
        REG_POLL:    cfg_r.poll_period_ms     <= cfg_wdata[SHORT_W-1:0];
        REG_DELAY:   cfg_r.sample_delay_ms    <= cfg_wdata[SHORT_W-1:0];
        REG_FRESH:   cfg_r.fresh_age_ms       <= cfg_wdata[LONG_W-1:0];
        REG_TIMEOUT: cfg_r.no_data_timeout_ms <= cfg_wdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("stages not empty after reset");

  // a held tick keeps its payload in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a stalled tick");

  // a result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && core_emit |-> out_free)
    else $error("output register overwritten");

  // an empty input register always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("not ready with empty input register");

endmodule

// ----- tb/tb_range_median3_sampler_unit.sv -----
`timescale 1ns / 1ps

module tb_range_median3_sampler_unit;
  import rm3s_pkg::*;

  class median_range_tracker;
    logic [SHORT_W-1:0] ground;
    logic [SHORT_W-1:0] poll;
    logic [SHORT_W-1:0] delay;
    logic [LONG_W-1:0]  fresh;
    logic [LONG_W-1:0]  timeout;
    logic [TIME_W-1:0]  last_poll;
    logic [TIME_W-1:0]  last_emit;
    logic [TIME_W-1:0]  last_valid;
    logic [SLOT_W-1:0]  wslot;
    logic [TIME_W-1:0]  stime[SLOT_N];
    logic signed [RANGE_W-1:0] srange[SLOT_N];
    out_item_t expected_ranges[$];

    function new();
      ground     = GROUND_RST;
      poll       = POLL_RST;
      delay      = DELAY_RST;
      fresh      = FRESH_RST;
      timeout    = TIMEOUT_RST;
      last_poll  = '0;
      last_emit  = '0;
      last_valid = '0;
      wslot      = '0;
      for (int i = 0; i < SLOT_N; i++) begin
        stime[i]  = '0;
        srange[i] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_t r, int v);
      case (r)
        REG_GROUND:  ground  = SHORT_W'(v);
        REG_POLL:    poll    = SHORT_W'(v);
        REG_DELAY:   delay   = SHORT_W'(v);
        REG_FRESH:   fresh   = LONG_W'(v);
        REG_TIMEOUT: timeout = LONG_W'(v);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_ranges.size();
    endfunction

    function void take_tick(in_item_t t);
      logic [TIME_W-1:0] age;
      bit all_fresh;
      int lo;
      int hi;
      int m;
      int r;
      out_item_t e;
      age = t.now_ms - last_poll;
      if (age <= TIME_W'(poll)) return;
      last_poll = t.now_ms;
      if (t.sensor_healthy) begin
        wslot = (wslot >= 2) ? '0 : wslot + 1'b1;
        stime[wslot]  = t.now_ms - TIME_W'(delay);
        srange[wslot] = t.raw_range_cm;
      end
      all_fresh = 1'b1;
      for (int i = 0; i < SLOT_N; i++) begin
        age = t.now_ms - stime[i];
        if (age >= TIME_W'(fresh)) all_fresh = 1'b0;
      end
      if (all_fresh) begin
        if (srange[0] > srange[1]) begin
          lo = 1;
          hi = 0;
        end else begin
          lo = 0;
          hi = 1;
        end
        if (srange[2] > srange[hi]) m = hi;
        else if (srange[2] < srange[lo]) m = lo;
        else m = 2;
        r = srange[m];
        if (r < int'(ground)) r = int'(ground);
        if (r > OUT_MAX) r = OUT_MAX;
        if (stime[m] > last_emit) last_emit = stime[m];
        last_valid = t.now_ms;
        e.range_cm      = OUT_W'(r);
        e.stamp_ms      = last_emit;
        e.from_fallback = 1'b0;
        expected_ranges.push_back(e);
      end else begin
        age = t.now_ms - last_valid;
        if (!t.takeoff_seen && age > TIME_W'(timeout)) begin
          last_emit  = t.now_ms;
          last_valid = t.now_ms;
          e.range_cm      = OUT_W'(ground);
          e.stamp_ms      = t.now_ms;
          e.from_fallback = 1'b1;
          expected_ranges.push_back(e);
        end
      end
    endfunction

    function string compare_range(out_item_t got);
      out_item_t e;
      string msg;
      msg = "";
      if (expected_ranges.size() == 0) return " range transfer with nothing expected";
      e = expected_ranges.pop_front();
      if (got.range_cm !== e.range_cm)
        msg = {msg, $sformatf(" range_cm got %0d exp %0d", got.range_cm, e.range_cm)};
      if (got.stamp_ms !== e.stamp_ms)
        msg = {msg, $sformatf(" stamp_ms got %0h exp %0h", got.stamp_ms, e.stamp_ms)};
      if (got.from_fallback !== e.from_fallback)
        msg = {msg, $sformatf(" from_fallback got %0b exp %0b",
                              got.from_fallback, e.from_fallback)};
      return msg;
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  median_range_tracker tracker;
  logic [TIME_W-1:0] cur_now = '0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int mismatches    = 0;
  int ticks_sent    = 0;
  int ranges_seen   = 0;
  int fallback_seen = 0;
  int settings_done = 1;

  range_median3_sampler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t:%s", $time, what);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      ranges_seen++;
      if (out_data.from_fallback) fallback_seen++;
      msg = tracker.compare_range(out_data);
      if (msg != "") report_mismatch(msg);
    end
  end

  task automatic send_tick(input in_item_t t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_tick(t);
    cur_now = t.now_ms;
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic send_reading(input logic [TIME_W-1:0] now, input bit ok, input int raw,
                              input bit tko);
    in_item_t t;
    t.now_ms         = now;
    t.sensor_healthy = ok;
    t.raw_range_cm   = RAW_W'(raw);
    t.takeoff_seen   = tko;
    send_tick(t);
  endtask

  function automatic in_item_t make_tick();
    in_item_t t;
    int sel;
    int p;
    p   = int'(tracker.poll);
    sel = $urandom_range(0, 99);
    if (sel < 10) t.now_ms = cur_now + $urandom_range(0, p);
    else if (sel < 82) t.now_ms = cur_now + p + 1 + $urandom_range(0, p / 4 + 3);
    else if (sel < 92) t.now_ms = cur_now + $urandom_range(300, 12000);
    else t.now_ms = $urandom();
    t.sensor_healthy = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 99) < 60) t.raw_range_cm = RAW_W'($urandom_range(0, 1200));
    else t.raw_range_cm = RAW_W'($urandom());
    t.takeoff_seen = ($urandom_range(0, 99) < 30);
    return t;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= CFG_W'(v);
    tracker.set_reg(r, v);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int g, input int p, input int d, input int f,
                               input int to);
    wait_drained();
    // ticks without a result may still sit in the input register
    repeat (4) @(negedge clk);
    write_reg(REG_GROUND, g);
    write_reg(REG_POLL, p);
    write_reg(REG_DELAY, d);
    write_reg(REG_FRESH, f);
    write_reg(REG_TIMEOUT, to);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_idle_pct = 13;
    rx_idle_pct = 71;

    // never-written slots, range extremes, floor, median ties
    send_reading(32'd0, 1'b1, 100, 1'b0);
    send_reading(32'd51, 1'b1, 100, 1'b0);
    send_reading(32'd102, 1'b1, 32767, 1'b0);
    send_reading(32'd153, 1'b1, -32768, 1'b0);
    send_reading(32'd204, 1'b1, -1, 1'b0);
    send_reading(32'd255, 1'b1, 300, 1'b0);
    send_reading(32'd306, 1'b1, 300, 1'b0);
    send_reading(32'd357, 1'b1, 300, 1'b0);
    send_reading(32'd380, 1'b1, 7, 1'b0);
    send_reading(32'd420, 1'b1, 3, 1'b0);
    send_reading(32'd471, 1'b1, 3, 1'b0);
    send_reading(32'd522, 1'b1, 2, 1'b0);
    // stale slots: ground fallback, suppressed after takeoff
    send_reading(32'd1200, 1'b0, 0, 1'b0);
    send_reading(32'd1300, 1'b0, 0, 1'b1);
    send_reading(32'd1500, 1'b0, 0, 1'b0);
    // median stamp must not fall below the fallback stamp
    send_reading(32'd1551, 1'b1, 50, 1'b0);
    send_reading(32'd1602, 1'b1, 60, 1'b0);
    send_reading(32'd1653, 1'b1, 40, 1'b0);
    // time wrap, stamp kept by the unsigned compare
    send_reading(32'hFFFF_FFF0, 1'b1, 20, 1'b0);
    send_reading(32'h0000_0030, 1'b1, 21, 1'b0);
    send_reading(32'h0000_0070, 1'b1, 22, 1'b0);
    send_reading(32'h0000_00B0, 1'b1, 23, 1'b0);
    send_reading(32'h8000_0000, 1'b1, -5, 1'b1);
    send_reading(32'h8000_012C, 1'b0, -5, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(1000, 1, 1000, 10000, 10000);
        2: apply_setting(0, 1000, 0, 1, 1);
        4: apply_setting(0, 0, 0, 0, 0);
        5: apply_setting(5, 50, 25, 500, 200);
        default: apply_setting($urandom_range(0, 1000), $urandom_range(1, 1000),
                               $urandom_range(0, 1000), $urandom_range(1, 10000),
                               $urandom_range(1, 10000));
      endcase
      if (ph < 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 71;
      end else if (ph < 6) begin
        tx_idle_pct = 71;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 6) hold_req = 1'b1;
      for (int i = 0; i < 50; i++) begin
        if (ph == 7 && i == 25) wait_drained();
        send_tick(make_tick());
      end
    end

    wait_drained();
    repeat (6) @(negedge clk);
    if (tracker.pending() != 0)
      report_mismatch($sformatf(" %0d expected ranges never arrived", tracker.pending()));
    $display("%0d ticks sent over %0d register settings, %0d ranges checked (%0d fallback)",
             ticks_sent, settings_done, ranges_seen, fallback_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
